// ----- rtl/bounded_list_with_ordered_insert_top_defines.svh -----
// Assertion macros for the checker file.
`ifndef BOUNDED_LIST_WITH_ORDERED_INSERT_TOP_DEFINES_SVH
`define BOUNDED_LIST_WITH_ORDERED_INSERT_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define BLOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define BLOI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bloi_pkg.sv -----
package bloi_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  // Result word layout, lowest bit first.
  localparam int OFS_FRONT  = 0;
  localparam int OFS_BACK   = OFS_FRONT + VALUE_WIDTH;
  localparam int OFS_COUNT  = OFS_BACK + VALUE_WIDTH;
  localparam int OFS_EMPTY  = OFS_COUNT + CNT_W;
  localparam int OFS_FOUND  = OFS_EMPTY + 1;
  localparam int OFS_STATUS = OFS_FOUND + 1;
  localparam int OUT_BITS   = OFS_STATUS + STATUS_W;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W       = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY      = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_SORTED     = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_REMOVE     = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_PUSH_FRONT,
    CM_PUSH_BACK,
    CM_SORTED,
    CM_POP_FRONT,
    CM_REMOVE
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_DONE
  } state_t;

  // Broadcast to every cell.
  typedef struct packed {
    cell_mode_t mode;
    value_t     value;
  } cell_cmd_t;

  // Where a cell sits relative to the fill level.
  typedef struct packed {
    logic valid;
    logic at_count;
  } cell_pos_t;

  // Per-cell status handed to the neighbor and the controller.
  typedef struct packed {
    logic eq;
    logic pfx;
  } cell_stat_t;

endpackage

// ----- rtl/bloi_cell.sv -----
module bloi_cell (
  input  logic                 clk,
  input  bloi_pkg::cell_cmd_t  cmd,
  input  bloi_pkg::cell_pos_t  pos,
  input  bloi_pkg::value_t     left_val,
  input  bloi_pkg::value_t     right_val,
  input  logic                 pfx_in,
  output bloi_pkg::value_t     val,
  output bloi_pkg::cell_stat_t stat
);
  import bloi_pkg::*;

  value_t val_r;
  value_t val_nxt;
  logic   eq;
  logic   le;
  logic   hit;
  logic   pfx_out;

  assign eq = pos.valid && (val_r == cmd.value);
  assign le = pos.valid && (cmd.value <= val_r);

  always_comb begin
    case (cmd.mode)
      CM_PUSH_FRONT: hit = 1'b1;
      CM_PUSH_BACK:  hit = pos.at_count;
      CM_SORTED:     hit = le || pos.at_count;
      CM_POP_FRONT:  hit = 1'b1;
      CM_REMOVE:     hit = eq;
      default:       hit = 1'b0;
    endcase
  end

  assign pfx_out = pfx_in || hit;

  always_comb begin
    val_nxt = val_r;
    case (cmd.mode)
      CM_PUSH_FRONT, CM_PUSH_BACK, CM_SORTED: begin
        // Cells past the insert point shift back by one.
        if (pfx_in) begin
          val_nxt = left_val;
        end else if (hit) begin
          val_nxt = cmd.value;
        end
      end
      CM_POP_FRONT, CM_REMOVE: begin
        // Cells from the removed slot on pull from the right.
        if (pfx_out) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign stat.eq  = eq;
  assign stat.pfx = pfx_out;

endmodule

// ----- rtl/bounded_list_with_ordered_insert_top.sv -----
// Channel | Direction | Handshake         | Payload
// in      | slave     | in_tvalid/tready  | tdata: value; tuser: operation
// out     | master    | out_tvalid/tready | tdata: front, back, count, empty, found, status
//
// A request passes from acceptance through the execute and done states to a
// result in the output register; a remove-all-equal request also stays in the
// remove state while matches remain, since the cell chain drops one match a cycle.
// The next request is taken once the controller is back in idle, even while
// the previous result still waits in the output register.
// Reset (rst_n low, synchronous) empties the list and drops any result.
// A stalled output holds the controller before the result write.
module bounded_list_with_ordered_insert_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bloi_pkg::IN_W-1:0]     in_tdata,  // [31:0] value
  input  logic [bloi_pkg::OP_W-1:0]     in_tuser,  // [2:0] operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] front_value, [63:32] back_value, [68:64] entry_count,
  // [69] is_empty, [70] found, [72:71] status, [79:73] zero
  output logic [bloi_pkg::OUT_W-1:0]    out_tdata
);
  import bloi_pkg::*;

  state_t        state_r, state_nxt;
  op_t           op_r;
  value_t        val_r;
  count_t        count_r, count_nxt;
  logic          found_r, found_nxt;
  status_t       status_r, status_nxt;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  cell_cmd_t     cmd;
  cell_pos_t     pos   [DEPTH];
  cell_stat_t    stat  [DEPTH];
  value_t        vals  [DEPTH];
  logic          any_eq;
  logic          slot_free;
  logic          in_acc;
  value_t        front_val;
  value_t        back_val;
  logic [OUT_W-1:0] result;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Cell chain: each cell sees its neighbors and the prefix from the left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    value_t rv;
    logic   pin;

    assign pos[i].valid    = count_t'(i) < count_r;
    assign pos[i].at_count = count_r == count_t'(i);

    if (i == 0) begin : g_first
      assign lv  = cmd.value;
      assign pin = 1'b0;
    end else begin : g_mid
      assign lv  = vals[i-1];
      assign pin = stat[i-1].pfx;
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    bloi_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos[i]),
      .left_val  (lv),
      .right_val (rv),
      .pfx_in    (pin),
      .val       (vals[i]),
      .stat      (stat[i])
    );
  end

  always_comb begin
    any_eq = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      any_eq = any_eq | stat[i].eq;
    end
  end

  // Controller: decide what the chain does this cycle.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    cmd.mode   = CM_HOLD;
    cmd.value  = val_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        found_nxt  = any_eq;
        status_nxt = STAT_DONE;
        state_nxt  = S_DONE;
        case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
            if (count_r == count_t'(DEPTH)) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + count_t'(1);
              case (op_r)
                OP_PUSH_FRONT: cmd.mode = CM_PUSH_FRONT;
                OP_PUSH_BACK:  cmd.mode = CM_PUSH_BACK;
                default:       cmd.mode = CM_SORTED;
              endcase
            end
          end
          OP_POP_FRONT: begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
            end else begin
              cmd.mode  = CM_POP_FRONT;
              count_nxt = count_r - count_t'(1);
            end
          end
          OP_POP_BACK: begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
            end else begin
              count_nxt = count_r - count_t'(1);
            end
          end
          OP_REMOVE: begin
            // Drop the first match now, then keep sweeping.
            cmd.mode = CM_REMOVE;
            if (any_eq) begin
              count_nxt = count_r - count_t'(1);
              state_nxt = S_REMOVE;
            end
          end
          default: cmd.mode = CM_HOLD;
        endcase
      end
      S_REMOVE: begin
        cmd.mode = CM_REMOVE;
        if (any_eq) begin
          count_nxt = count_r - count_t'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Pick the back entry by fill level.
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_r == count_t'(i + 1)) begin
        back_val = vals[i];
      end
    end
  end

  assign front_val = (count_r == '0) ? '0 : vals[0];

  always_comb begin
    result = '0;
    result[OFS_FRONT +: VALUE_WIDTH] = front_val;
    result[OFS_BACK +: VALUE_WIDTH]  = back_val;
    result[OFS_COUNT +: CNT_W]       = count_r;
    result[OFS_EMPTY]                = (count_r == '0);
    result[OFS_FOUND]                = found_r;
    result[OFS_STATUS +: STATUS_W]   = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      status_r    <= STAT_DONE;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the request; hold the result word until it is taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_tuser);
      val_r <= value_t'(in_tdata[VALUE_WIDTH-1:0]);
    end
    if (state_r == S_DONE && slot_free) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/bloi_checker.sv -----
`include "bounded_list_with_ordered_insert_top_defines.svh"

module bloi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [bloi_pkg::IN_W-1:0]  in_tdata,
  input logic [bloi_pkg::OP_W-1:0]  in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [bloi_pkg::OUT_W-1:0] out_tdata
);
  import bloi_pkg::*;

  // Hold a stalled result.
  `BLOI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // Empty flag agrees with the count.
  `BLOI_ASSERT(a_empty_flag, out_tvalid |-> (out_tdata[OFS_EMPTY] == (out_tdata[OFS_COUNT +: CNT_W] == '0)), "empty flag disagrees with count")

  // An empty list shows zero front and back.
  `BLOI_ASSERT(a_empty_zero, out_tvalid && out_tdata[OFS_EMPTY] |-> (out_tdata[OFS_BACK +: VALUE_WIDTH] == '0) && (out_tdata[OFS_FRONT +: VALUE_WIDTH] == '0), "empty list shows data")

  // Count stays in range and status is a known code.
  `BLOI_ASSERT(a_ranges, out_tvalid |-> (out_tdata[OFS_COUNT +: CNT_W] <= CNT_W'(DEPTH)) && (out_tdata[OFS_STATUS +: STATUS_W] != 2'd3), "count or status out of range")

  // Reset drops any pending result.
  `BLOI_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind bounded_list_with_ordered_insert_top bloi_checker u_bloi_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  import bloi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation code 7 has no name in the package; the block treats it as a query.
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  localparam int RANDOM_REQUESTS = 550;
  // Hold stimulus idling off for the last stretch of the run.
  localparam int CALM_TAIL       = 60;
  // Long receiver hold-off, started once this many results have arrived.
  localparam int HOLD_AFTER      = 100;
  localparam int HOLD_CYCLES     = 80;
  // Worst request latency: a remove that drops every entry, plus margin.
  localparam int DRAIN_CYCLES    = 3 + DEPTH + 8;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    value_t          value;
  } request_t;

  typedef struct packed {
    value_t  front;
    value_t  back;
    count_t  count;
    logic    empty;
    logic    found;
    status_t status;
  } list_state_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;   // [31:0] value
  logic [OP_W-1:0]     in_tuser = '0;   // [2:0] operation
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [31:0] front, [63:32] back, [68:64] count, [69] empty, [70] found,
  // [72:71] status
  logic [OUT_W-1:0]    out_tdata;

  request_t    pending_q[$];    // requests not yet offered
  list_state_t expected_q[$];   // predicted results, oldest first
  value_t      shadow_list[$];  // predicted list contents, front at index 0

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  logic        calm = 1'b0;

  bounded_list_with_ordered_insert_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow list and return the state the block
  // should report afterwards. Membership is checked before the update.
  function automatic list_state_t apply_request(request_t req);
    list_state_t res;
    value_t      rebuilt[$];
    int          slot;
    bit          placed;
    res.found  = 1'b0;
    res.status = STAT_DONE;
    foreach (shadow_list[i]) begin
      if (shadow_list[i] == req.value) res.found = 1'b1;
    end
    case (req.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
        if (shadow_list.size() >= DEPTH) begin
          res.status = STAT_FULL;
        end else if (req.op == OP_PUSH_FRONT) begin
          shadow_list.push_front(req.value);
        end else if (req.op == OP_PUSH_BACK) begin
          shadow_list.push_back(req.value);
        end else begin
          // Place before the first entry that is not smaller (signed order).
          placed = 1'b0;
          foreach (shadow_list[i]) begin
            if (!placed && req.value <= shadow_list[i]) begin
              rebuilt.push_back(req.value);
              placed = 1'b1;
            end
            rebuilt.push_back(shadow_list[i]);
          end
          if (!placed) rebuilt.push_back(req.value);
          shadow_list = rebuilt;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_list.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_list.pop_front());
      end
      OP_POP_BACK: begin
        if (shadow_list.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_list.pop_back());
      end
      OP_REMOVE: begin
        foreach (shadow_list[i]) begin
          if (shadow_list[i] != req.value) rebuilt.push_back(shadow_list[i]);
        end
        shadow_list = rebuilt;
      end
      default: ;  // query and the spare code leave the list alone
    endcase
    slot      = shadow_list.size();
    res.count = count_t'(slot);
    res.empty = (slot == 0);
    res.front = (slot > 0) ? shadow_list[0] : '0;
    res.back  = (slot > 0) ? shadow_list[slot-1] : '0;
    return res;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, value_t value);
    request_t req;
    req.op    = op;
    req.value = value;
    pending_q.push_back(req);
  endtask

  // Favor a small pool so duplicates, hits and removals happen often.
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return value_t'(32'sh7fff_ffff);
      1: return value_t'(32'sh8000_0000);
      2, 3, 4, 5: return value_t'($signed($urandom_range(0, 6)) - 3);
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 25) return OP_PUSH_FRONT;
        if (roll < 50) return OP_PUSH_BACK;
        if (roll < 82) return OP_SORTED;
        if (roll < 87) return OP_QUERY;
        if (roll < 92) return OP_POP_FRONT;
        if (roll < 97) return OP_POP_BACK;
        return OP_REMOVE;
      end
      MIX_DRAIN: begin
        if (roll < 10) return OP_SORTED;
        if (roll < 40) return OP_POP_FRONT;
        if (roll < 70) return OP_POP_BACK;
        if (roll < 90) return OP_REMOVE;
        if (roll < 95) return OP_QUERY;
        return OP_SPARE;
      end
      default: return OP_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Build the whole request list, then release reset and wait for the end.
  initial begin
    int   left;
    int   run;
    mix_t mix;

    // Empty list: both pops, a remove, a query and the spare code.
    add_request(OP_QUERY, '0);
    add_request(OP_POP_FRONT, 32'sd9);
    add_request(OP_POP_BACK, -32'sd9);
    add_request(OP_REMOVE, 32'sd5);
    add_request(OP_SPARE, '0);
    // Value extremes at both ends, then sorted inserts around them.
    add_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    add_request(OP_PUSH_FRONT, 32'sh8000_0000);
    add_request(OP_SORTED, 32'sd0);
    add_request(OP_SORTED, -32'sd1);
    add_request(OP_SORTED, 32'sd0);              // lands before its equal
    add_request(OP_SORTED, 32'sh7fff_ffff);      // goes before the max at the back
    add_request(OP_SORTED, 32'sh8000_0000);      // front
    add_request(OP_QUERY, 32'sd0);
    add_request(OP_REMOVE, 32'sd0);              // drops two equal entries
    add_request(OP_REMOVE, 32'sd12345);          // no match
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_SPARE, -32'sd1);
    add_request(OP_PUSH_BACK, 32'shaaaa_aaaa);
    add_request(OP_PUSH_FRONT, 32'sh5555_5555);
    add_request(OP_REMOVE, 32'shaaaa_aaaa);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);                // empties the list

    // Random part in runs of one mix; start by filling so the full case shows.
    left = RANDOM_REQUESTS;
    mix  = MIX_FILL;
    while (left > 0) begin
      run = $urandom_range(30, 50);
      repeat (run) begin
        if (left > 0) add_request(pick_op(mix), pick_value());
        left--;
      end
      mix = mix_t'($urandom_range(0, 2));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Request driver: predict each accepted request, then offer the next one
  // or idle for a short burst. Hold the bus while a request waits.
  int unsigned   send_gap;
  request_t      next_req;
  list_state_t   predicted;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
      calm      <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = apply_request(request_t'({in_tuser, in_tdata[VALUE_WIDTH-1:0]}));
        expected_q.push_back(predicted);
      end
      calm <= (pending_q.size() < CALM_TAIL);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= $urandom_range(0, 2);
        end else if (pending_q.size() != 0) begin
          next_req  = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(next_req.value);
          in_tuser  <= next_req.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: short random stalls, plus one long hold-off that backs
  // the block up until it refuses new requests.
  int unsigned stall_left;
  int unsigned hold_left;
  logic        hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      hold_done  <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor: compare every accepted result with the oldest prediction.
  list_state_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("front_value", want.front, value_t'(out_tdata[OFS_FRONT +: VALUE_WIDTH]));
        check_field("back_value", want.back, value_t'(out_tdata[OFS_BACK +: VALUE_WIDTH]));
        check_field("entry_count", want.count, out_tdata[OFS_COUNT +: CNT_W]);
        check_field("is_empty", want.empty, out_tdata[OFS_EMPTY]);
        check_field("found", want.found, out_tdata[OFS_FOUND]);
        check_field("status", want.status, out_tdata[OFS_STATUS +: STATUS_W]);
      end
    end
  end

endmodule
